@@ rtl/m4inv_pkg.sv @@
// Shared types, constants and step decode tables for the 4x4 matrix inverse unit.
package m4inv_pkg;

  localparam int ACC_W       = 64;
  localparam int PROD_W      = 128;
  localparam int RECIP_SHIFT = 62;

  typedef enum logic [1:0] {
    SRC_MAT,
    SRC_MIN,
    SRC_COF,
    SRC_RCP
  } src_e;

  typedef enum logic [1:0] {
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_MIN,
    DST_COF,
    DST_DET
  } dst_e;

  typedef enum logic [1:0] {
    PH_MINOR,
    PH_COF,
    PH_DET,
    PH_OUT
  } phase_e;

  typedef struct packed {
    src_e       a_src;
    logic [3:0] a_idx;
    src_e       b_src;
    logic [3:0] b_idx;
    acc_op_e    op;
    dst_e       dst;
    logic [3:0] dst_idx;
    logic       neg;
  } step_t;

  typedef struct packed {
    logic       rd_en;
    src_e       rd_src;
    logic [3:0] rd_idx;
    logic       lat_a;
    logic       lat_b;
    logic       mul_en;
    logic [1:0] mul_part;
    logic       rnd_en;
    logic       out_mode;
    logic       acc_en;
    acc_op_e    acc_op;
    dst_e       dst;
    logic [3:0] dst_idx;
    logic       neg;
    logic       div_init;
    logic       div_step;
    logic       rcp_set;
    logic       out_load;
    logic       out_zero;
    logic [3:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_stat_t;

  // each minor is m[a]*m[b] - m[c]*m[d]
  localparam logic [3:0] MINOR_TAB [3][6][4] = '{
    '{'{4'd2, 4'd7, 4'd6, 4'd3},   '{4'd2, 4'd11, 4'd10, 4'd3},
      '{4'd2, 4'd15, 4'd14, 4'd3}, '{4'd6, 4'd11, 4'd10, 4'd7},
      '{4'd6, 4'd15, 4'd14, 4'd7}, '{4'd10, 4'd15, 4'd14, 4'd11}},
    '{'{4'd1, 4'd7, 4'd5, 4'd3},   '{4'd1, 4'd11, 4'd9, 4'd3},
      '{4'd1, 4'd15, 4'd13, 4'd3}, '{4'd5, 4'd11, 4'd9, 4'd7},
      '{4'd5, 4'd15, 4'd13, 4'd7}, '{4'd9, 4'd15, 4'd13, 4'd11}},
    '{'{4'd6, 4'd1, 4'd2, 4'd5},   '{4'd10, 4'd1, 4'd2, 4'd9},
      '{4'd14, 4'd1, 4'd2, 4'd13}, '{4'd10, 4'd5, 4'd6, 4'd9},
      '{4'd14, 4'd5, 4'd6, 4'd13}, '{4'd14, 4'd9, 4'd10, 4'd13}}
  };

  // set, negate, then (minor, element) for the terms + - +
  localparam logic [3:0] COF_TAB [16][8] = '{
    '{4'd0, 4'd0, 4'd5, 4'd5, 4'd4, 4'd9, 4'd3, 4'd13},
    '{4'd0, 4'd1, 4'd5, 4'd1, 4'd2, 4'd9, 4'd1, 4'd13},
    '{4'd0, 4'd0, 4'd4, 4'd1, 4'd2, 4'd5, 4'd0, 4'd13},
    '{4'd0, 4'd1, 4'd3, 4'd1, 4'd1, 4'd5, 4'd0, 4'd9},
    '{4'd0, 4'd1, 4'd5, 4'd4, 4'd4, 4'd8, 4'd3, 4'd12},
    '{4'd0, 4'd0, 4'd5, 4'd0, 4'd2, 4'd8, 4'd1, 4'd12},
    '{4'd0, 4'd1, 4'd4, 4'd0, 4'd2, 4'd4, 4'd0, 4'd12},
    '{4'd0, 4'd0, 4'd3, 4'd0, 4'd1, 4'd4, 4'd0, 4'd8},
    '{4'd1, 4'd0, 4'd5, 4'd4, 4'd4, 4'd8, 4'd3, 4'd12},
    '{4'd1, 4'd1, 4'd5, 4'd0, 4'd2, 4'd8, 4'd1, 4'd12},
    '{4'd1, 4'd0, 4'd4, 4'd0, 4'd2, 4'd4, 4'd0, 4'd12},
    '{4'd1, 4'd1, 4'd3, 4'd0, 4'd1, 4'd4, 4'd0, 4'd8},
    '{4'd2, 4'd1, 4'd5, 4'd4, 4'd4, 4'd8, 4'd3, 4'd12},
    '{4'd2, 4'd0, 4'd5, 4'd0, 4'd2, 4'd8, 4'd1, 4'd12},
    '{4'd2, 4'd1, 4'd4, 4'd0, 4'd2, 4'd4, 4'd0, 4'd12},
    '{4'd2, 4'd0, 4'd3, 4'd0, 4'd1, 4'd4, 4'd0, 4'd8}
  };

  // Decode one multiply-accumulate step of the sequence.
  function automatic step_t get_step(phase_e ph, logic [1:0] set, logic [3:0] idx,
                                     logic [1:0] term);
    step_t      s;
    logic [2:0] pa;
    logic [2:0] pb;
    s  = '0;
    pa = 3'({term, 1'b0}) + 3'd2;
    pb = 3'({term, 1'b0}) + 3'd3;
    case (ph)
      PH_MINOR: begin
        s.a_src   = SRC_MAT;
        s.b_src   = SRC_MAT;
        s.a_idx   = MINOR_TAB[set][idx[3:1]][{idx[0], 1'b0}];
        s.b_idx   = MINOR_TAB[set][idx[3:1]][{idx[0], 1'b1}];
        s.op      = idx[0] ? ACC_SUB : ACC_LOAD;
        s.dst     = idx[0] ? DST_MIN : DST_NONE;
        s.dst_idx = {1'b0, idx[3:1]};
      end
      PH_COF: begin
        s.a_src   = SRC_MIN;
        s.b_src   = SRC_MAT;
        s.a_idx   = COF_TAB[idx][pa];
        s.b_idx   = COF_TAB[idx][pb];
        s.op      = (term == 2'd0) ? ACC_LOAD : ((term == 2'd1) ? ACC_SUB : ACC_ADD);
        s.dst     = (term == 2'd2) ? DST_COF : DST_NONE;
        s.dst_idx = idx;
        s.neg     = COF_TAB[idx][1][0];
      end
      PH_DET: begin
        s.a_src   = SRC_COF;
        s.b_src   = SRC_MAT;
        s.a_idx   = {2'b00, term};
        s.b_idx   = {term, 2'b00};
        s.op      = (term == 2'd0) ? ACC_LOAD : ACC_ADD;
        s.dst     = (term == 2'd3) ? DST_DET : DST_NONE;
      end
      default: begin
        s.a_src   = SRC_COF;
        s.b_src   = SRC_RCP;
        s.a_idx   = idx;
        s.op      = ACC_LOAD;
        s.dst     = DST_NONE;
      end
    endcase
    return s;
  endfunction

endpackage

@@ rtl/m4inv_if.sv @@
// Stream interfaces for the matrix element input and the inverse element output.
interface m4inv_in_if #(
  parameter int ELEM_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic [3:0]                  elem_index;
  logic signed [ELEM_BITS-1:0] elem_value;
  logic                        go;

  modport source (output valid, elem_index, elem_value, go, input ready);
  modport sink   (input valid, elem_index, elem_value, go, output ready);
endinterface

interface m4inv_out_if #(
  parameter int ELEM_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic [3:0]                  out_index;
  logic signed [ELEM_BITS-1:0] out_value;
  logic                        singular;
  logic                        saturated;
  logic                        last_out;

  modport source (output valid, out_index, out_value, singular, saturated, last_out,
                  input ready);
  modport sink   (input valid, out_index, out_value, singular, saturated, last_out,
                  output ready);
endinterface

@@ rtl/m4inv_datapath.sv @@
// Datapath: element store, minor/cofactor stores, shared multiplier, accumulator, divider.
module m4inv_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int ELEM_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        in_we_i,
  input  logic [3:0]                  in_index_i,
  input  logic [ELEM_BITS-1:0]        in_value_i,
  input  m4inv_pkg::dp_cmd_t          cmd_i,
  output m4inv_pkg::dp_stat_t         stat_o,
  output logic [3:0]                  out_index_o,
  output logic [ELEM_BITS-1:0]        out_value_o,
  output logic                        singular_o,
  output logic                        saturated_o,
  output logic                        last_out_o
);
  import m4inv_pkg::*;

  localparam int OUT_SHIFT = RECIP_SHIFT - FRAC_BITS;
  localparam logic [PROD_W-1:0] ONE_P = PROD_W'(1);
  localparam logic [ACC_W-1:0] MAX_V = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] MIN_V = {1'b1, {(ACC_W-1){1'b0}}};

  logic [ELEM_BITS-1:0] mat_mem [16];
  logic [ACC_W-1:0]     min_mem [6];
  logic [5:0]           msat_q;
  logic [ACC_W-1:0]     cof_mem [16];
  logic [15:0]          csat_q;

  logic [ELEM_BITS-1:0] mat_rd_q;
  logic [ACC_W-1:0]     min_rd_q;
  logic                 min_flag_q;
  logic [ACC_W-1:0]     cof_rd_q;
  logic                 cof_flag_q;
  src_e                 rd_src_q;
  logic [ACC_W-1:0]     rd_val;
  logic                 rd_flag;
  logic [ACC_W-1:0]     rd_mag;

  logic [ACC_W-1:0]     a_mag_q, b_mag_q;
  logic                 a_neg_q, b_neg_q, a_flag_q, b_flag_q;
  logic [PROD_W-1:0]    prod_q;
  logic [63:0]          pp;
  logic [ACC_W-1:0]     res_q;
  logic                 res_sat_q;

  logic [PROD_W-1:0]    rnd_sum, q_full, lim;
  logic                 p_neg, p_sat;
  logic [ACC_W-1:0]     q_cl;

  logic [ACC_W-1:0]     acc_q, acc_d, wr_val;
  logic                 acc_sat_q, acc_sat_d, wr_sat;
  logic signed [ACC_W:0] sum65;

  logic [ACC_W-1:0]     det_q, recip_q, dm_q, num_q, rem_q, det_mag;
  logic                 dsat_q;
  logic [ACC_W:0]       rem_sh;
  logic                 rem_ge;

  logic [3:0]           out_idx_q;
  logic [ELEM_BITS-1:0] out_val_q;
  logic                 out_sing_q, out_sat_q;

  // element store
  always_ff @(posedge clk_i) begin
    if (in_we_i) begin
      mat_mem[in_index_i] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      mat_rd_q <= mat_mem[cmd_i.rd_idx];
    end
  end

  // minor and cofactor stores, written by the accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && cmd_i.dst == DST_MIN) begin
      min_mem[cmd_i.dst_idx[2:0]] <= wr_val;
      msat_q[cmd_i.dst_idx[2:0]]  <= wr_sat;
    end
    if (cmd_i.acc_en && cmd_i.dst == DST_COF) begin
      cof_mem[cmd_i.dst_idx] <= wr_val;
      csat_q[cmd_i.dst_idx]  <= wr_sat;
    end
    if (cmd_i.rd_en) begin
      min_rd_q   <= min_mem[cmd_i.rd_idx[2:0]];
      min_flag_q <= msat_q[cmd_i.rd_idx[2:0]];
      cof_rd_q   <= cof_mem[cmd_i.rd_idx];
      cof_flag_q <= csat_q[cmd_i.rd_idx];
      rd_src_q   <= cmd_i.rd_src;
    end
  end

  always_comb begin
    case (rd_src_q)
      SRC_MAT: begin
        rd_val  = {{(ACC_W-ELEM_BITS){mat_rd_q[ELEM_BITS-1]}}, mat_rd_q};
        rd_flag = 1'b0;
      end
      SRC_MIN: begin
        rd_val  = min_rd_q;
        rd_flag = min_flag_q;
      end
      SRC_COF: begin
        rd_val  = cof_rd_q;
        rd_flag = cof_flag_q;
      end
      default: begin
        rd_val  = recip_q;
        rd_flag = dsat_q;
      end
    endcase
    rd_mag = rd_val[ACC_W-1] ? (ACC_W'(0) - rd_val) : rd_val;
  end

  // operands in sign-magnitude form
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      a_mag_q  <= rd_mag;
      a_neg_q  <= rd_val[ACC_W-1];
      a_flag_q <= rd_flag;
    end
    if (cmd_i.lat_b) begin
      b_mag_q  <= rd_mag;
      b_neg_q  <= rd_val[ACC_W-1];
      b_flag_q <= rd_flag;
    end
  end

  // one 32x32 partial product per cycle
  assign pp = 64'(a_mag_q[32*cmd_i.mul_part[1] +: 32]) *
              64'(b_mag_q[32*cmd_i.mul_part[0] +: 32]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_part)
        2'd0:    prod_q <= PROD_W'(pp);
        2'd3:    prod_q <= prod_q + (PROD_W'(pp) << 64);
        default: prod_q <= prod_q + (PROD_W'(pp) << 32);
      endcase
    end
  end

  // round to nearest (ties away), shift and clip
  always_comb begin
    p_neg   = a_neg_q ^ b_neg_q;
    rnd_sum = prod_q + (cmd_i.out_mode ? (ONE_P << (OUT_SHIFT - 1)) :
                                         (ONE_P << (FRAC_BITS - 1)));
    q_full  = cmd_i.out_mode ? (rnd_sum >> OUT_SHIFT) : (rnd_sum >> FRAC_BITS);
    lim     = (cmd_i.out_mode ? (ONE_P << (ELEM_BITS - 1)) : (ONE_P << (ACC_W - 1))) -
              (p_neg ? PROD_W'(0) : PROD_W'(1));
    p_sat   = q_full > lim;
    q_cl    = p_sat ? lim[ACC_W-1:0] : q_full[ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_en) begin
      res_q     <= p_neg ? (ACC_W'(0) - q_cl) : q_cl;
      res_sat_q <= p_sat | a_flag_q | b_flag_q;
    end
  end

  // saturating accumulate, optional saturating negate on write
  always_comb begin
    sum65 = (cmd_i.acc_op == ACC_SUB) ?
            ($signed({acc_q[ACC_W-1], acc_q}) - $signed({res_q[ACC_W-1], res_q})) :
            ($signed({acc_q[ACC_W-1], acc_q}) + $signed({res_q[ACC_W-1], res_q}));
    case (cmd_i.acc_op) inside
      ACC_SUB, ACC_ADD: begin
        if (sum65[ACC_W] != sum65[ACC_W-1]) begin
          acc_d     = sum65[ACC_W] ? MIN_V : MAX_V;
          acc_sat_d = 1'b1;
        end else begin
          acc_d     = sum65[ACC_W-1:0];
          acc_sat_d = acc_sat_q | res_sat_q;
        end
        if (sum65[ACC_W] != sum65[ACC_W-1]) begin
          acc_sat_d = 1'b1;
        end
      end
      default: begin
        acc_d     = res_q;
        acc_sat_d = res_sat_q;
      end
    endcase
    wr_val = acc_d;
    wr_sat = acc_sat_d;
    if (cmd_i.neg) begin
      if (acc_d == MIN_V) begin
        wr_val = MAX_V;
        wr_sat = 1'b1;
      end else begin
        wr_val = ACC_W'(0) - acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q     <= acc_d;
      acc_sat_q <= acc_sat_d;
      if (cmd_i.dst == DST_DET) begin
        det_q  <= acc_d;
        dsat_q <= acc_sat_d;
      end
    end
  end

  assign stat_o.det_zero = (det_q == '0);

  // restoring divider, one quotient bit per cycle
  assign det_mag = det_q[ACC_W-1] ? (ACC_W'(0) - det_q) : det_q;
  assign rem_sh  = {rem_q, num_q[ACC_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dm_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dm_q  <= det_mag;
      num_q <= (ACC_W'(1) << RECIP_SHIFT) + (det_mag >> 1);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? ACC_W'(rem_sh - {1'b0, dm_q}) : rem_sh[ACC_W-1:0];
      num_q <= {num_q[ACC_W-2:0], rem_ge};
    end
    if (cmd_i.rcp_set) begin
      recip_q <= det_q[ACC_W-1] ? (ACC_W'(0) - num_q) : num_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= cmd_i.out_idx;
      out_val_q  <= cmd_i.out_zero ? '0 : res_q[ELEM_BITS-1:0];
      out_sat_q  <= cmd_i.out_zero ? 1'b0 : res_sat_q;
      out_sing_q <= cmd_i.out_zero;
    end
  end

  assign out_index_o = out_idx_q;
  assign out_value_o = out_val_q;
  assign singular_o  = out_sing_q;
  assign saturated_o = out_sat_q;
  assign last_out_o  = (out_idx_q == 4'd15);

endmodule

@@ rtl/m4inv_ctrl.sv @@
// Controller: sequences loading, minor/cofactor/determinant steps, division and emission.
module m4inv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_go_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output m4inv_pkg::dp_cmd_t  cmd_o,
  input  m4inv_pkg::dp_stat_t stat_i
);
  import m4inv_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_FETCH_A  = 12'b0000_0000_0010,
    ST_FETCH_B  = 12'b0000_0000_0100,
    ST_LOAD_B   = 12'b0000_0000_1000,
    ST_MUL      = 12'b0000_0001_0000,
    ST_ROUND    = 12'b0000_0010_0000,
    ST_ACC      = 12'b0000_0100_0000,
    ST_CHECK    = 12'b0000_1000_0000,
    ST_DIV      = 12'b0001_0000_0000,
    ST_RCP      = 12'b0010_0000_0000,
    ST_OUT_LOAD = 12'b0100_0000_0000,
    ST_EMIT     = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] set_q, set_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] term_q, term_d;
  logic [5:0] cnt_q, cnt_d;
  logic       sing_q, sing_d;
  step_t      step;

  assign step = get_step(phase_q, set_q, idx_q, term_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MINOR;
      set_q   <= '0;
      idx_q   <= '0;
      term_q  <= '0;
      cnt_q   <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      set_q   <= set_d;
      idx_q   <= idx_d;
      term_q  <= term_d;
      cnt_q   <= cnt_d;
      sing_q  <= sing_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    set_d       = set_q;
    idx_d       = idx_q;
    term_d      = term_q;
    cnt_d       = cnt_q;
    sing_d      = sing_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_go_i) begin
          phase_d = PH_MINOR;
          set_d   = '0;
          idx_d   = '0;
          term_d  = '0;
          sing_d  = 1'b0;
          state_d = ST_FETCH_A;
        end
      end
      ST_FETCH_A: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = step.a_src;
        cmd_o.rd_idx = step.a_idx;
        state_d      = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        cmd_o.lat_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = step.b_src;
        cmd_o.rd_idx = step.b_idx;
        state_d      = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        cmd_o.lat_b = 1'b1;
        cnt_d       = '0;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_part = cnt_q[1:0];
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.rnd_en   = 1'b1;
        cmd_o.out_mode = (phase_q == PH_OUT);
        state_d        = (phase_q == PH_OUT) ? ST_OUT_LOAD : ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_op  = step.op;
        cmd_o.dst     = step.dst;
        cmd_o.dst_idx = step.dst_idx;
        cmd_o.neg     = (step.dst == DST_COF) && step.neg;
        state_d       = ST_FETCH_A;
        case (phase_q)
          PH_MINOR: begin
            if (idx_q == 4'd11) begin
              phase_d = PH_COF;
              term_d  = '0;
              idx_d   = (set_q == 2'd0) ? 4'd0 : ((set_q == 2'd1) ? 4'd8 : 4'd12);
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          PH_COF: begin
            if (term_q == 2'd2) begin
              term_d = '0;
              if (idx_q == 4'd15) begin
                phase_d = PH_DET;
              end else if (idx_q == 4'd7 || idx_q == 4'd11) begin
                phase_d = PH_MINOR;
                set_d   = set_q + 2'd1;
                idx_d   = '0;
              end else begin
                idx_d = idx_q + 4'd1;
              end
            end else begin
              term_d = term_q + 2'd1;
            end
          end
          default: begin
            if (term_q == 2'd3) begin
              state_d = ST_CHECK;
            end else begin
              term_d = term_q + 2'd1;
            end
          end
        endcase
      end
      ST_CHECK: begin
        phase_d = PH_OUT;
        idx_d   = '0;
        if (stat_i.det_zero) begin
          sing_d  = 1'b1;
          state_d = ST_OUT_LOAD;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_RCP;
        end
      end
      ST_RCP: begin
        cmd_o.rcp_set = 1'b1;
        state_d       = ST_FETCH_A;
      end
      ST_OUT_LOAD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_zero = sing_q;
        cmd_o.out_idx  = idx_q;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == 4'd15) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = sing_q ? ST_OUT_LOAD : ST_FETCH_A;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/matrix4_inverse_unit.sv @@
// 4x4 matrix inverse by cofactors: element load, sequenced fixed-point inversion, result stream.
// Elements are written while the unit is idle; the beat with go also writes its element and
// starts the inversion: 88 multiply-accumulate steps on the one shared 32x32 multiplier,
// then the bit-serial reciprocal divider, then one multiply per result. Each further result
// is computed only after the sink has taken the last one; a singular matrix skips the divider
// and gives all-zero results flagged singular. Reset clears the controller; stores need no reset.
module matrix4_inverse_unit #(
  parameter int FRAC_BITS = 16,
  parameter int ELEM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  m4inv_in_if.sink    in_i,
  m4inv_out_if.source out_o
);
  import m4inv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  m4inv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_go_i     (in_i.go),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  m4inv_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .in_we_i     (in_i.valid & in_i.ready),
    .in_index_i  (in_i.elem_index),
    .in_value_i  (in_i.elem_value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_index_o (out_o.out_index),
    .out_value_o (out_o.out_value),
    .singular_o  (out_o.singular),
    .saturated_o (out_o.saturated),
    .last_out_o  (out_o.last_out)
  );

endmodule
